// ----- hw/rtl/dhc_pkg.sv -----
package dhc_pkg;

  localparam int DISP_W  = 8;
  localparam int SCALE_W = 9;
  localparam int HUE_W   = 8;
  localparam int NUMER_W = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef struct packed {
    logic [DISP_W-1:0]  max_disparity;
    logic [SCALE_W-1:0] saturation;
    logic [SCALE_W-1:0] value_level;
  } cfg_t;

endpackage

// ----- hw/rtl/dhc_if.sv -----
interface dhc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] disparity;

  modport source (output valid, output disparity, input ready);
  modport sink (input valid, input disparity, output ready);
endinterface

interface dhc_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink (input valid, input blue, input green, input red, output ready);
endinterface

// ----- hw/rtl/dhc_regs.sv -----
module dhc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dhc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dhc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dhc_pkg::cfg_t                cfg
);

  typedef enum logic [1:0] {
    REG_MAX_DISP = 2'd0,
    REG_SAT      = 2'd1,
    REG_VAL      = 2'd2
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_disparity <= 8'd255;
      cfg.saturation    <= 9'd256;
      cfg.value_level   <= 9'd256;
    end else if (wr) begin
      case (idx)
        REG_MAX_DISP: cfg.max_disparity <= pwdata[7:0];
        REG_SAT:      cfg.saturation    <= pwdata[8:0];
        REG_VAL:      cfg.value_level   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_DISP: prdata = 32'(cfg.max_disparity);
      REG_SAT:      prdata = 32'(cfg.saturation);
      REG_VAL:      prdata = 32'(cfg.value_level);
      default:      prdata = '0;
    endcase
  end

  a_sat_write: assert property (@(posedge clk) disable iff (rst)
    wr && idx == REG_SAT |=> cfg.saturation == $past(pwdata[8:0]))
    else $error("saturation register not updated by write");

endmodule

// ----- hw/rtl/dhc_hue_div.sv -----
module dhc_hue_div (
  input  logic                        clk,
  input  logic                        rst,
  input  dhc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dhc_pkg::DISP_W-1:0]  disparity,
  output logic                        hue_valid,
  input  logic                        hue_ready,
  output logic [dhc_pkg::HUE_W-1:0]   hue
);

  // stage 0 forms (max - d) * 240, stages 1..4 retire two quotient bits each
  localparam int NSTG = 5;

  logic [NSTG-1:0]                 vld;
  logic [NSTG-1:0]                 adv;
  logic [dhc_pkg::NUMER_W-1:0]     rem [NSTG-1];
  logic [dhc_pkg::HUE_W-1:0]       quo [NSTG];
  logic [dhc_pkg::DISP_W-1:0]      dclamp;
  logic [dhc_pkg::DISP_W-1:0]      diff;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || hue_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign dclamp = (disparity > cfg.max_disparity) ? cfg.max_disparity : disparity;
  assign diff   = cfg.max_disparity - dclamp;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0] <= {diff, 8'd0} - {4'd0, diff, 4'd0};
      quo[0] <= '0;
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_div
    localparam int HI = 9 - 2 * k;
    logic [dhc_pkg::NUMER_W-1:0] dh, dl, r1;
    logic                        b1, b0;

    always_comb begin
      dh = dhc_pkg::NUMER_W'(cfg.max_disparity) << HI;
      dl = dhc_pkg::NUMER_W'(cfg.max_disparity) << (HI - 1);
      b1 = rem[k-1] >= dh;
      r1 = b1 ? rem[k-1] - dh : rem[k-1];
      b0 = r1 >= dl;
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        quo[k] <= quo[k-1] | (dhc_pkg::HUE_W'(b1) << HI) | (dhc_pkg::HUE_W'(b0) << (HI - 1));
      end
    end

    if (k < NSTG - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[k]) rem[k] <= b0 ? r1 - dl : r1;
      end
    end
  end

  assign hue_valid = vld[NSTG-1];
  assign hue       = (cfg.max_disparity == '0) ? '0 : quo[NSTG-1];

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hue_valid |-> hue <= 8'd240)
    else $error("hue out of range");

  a_hue_hold: assert property (@(posedge clk) disable iff (rst)
    hue_valid && !hue_ready |=> hue_valid && $stable(quo[NSTG-1]))
    else $error("stalled hue lost");

endmodule

// ----- hw/rtl/dhc_shade.sv -----
module dhc_shade (
  input  logic                       clk,
  input  logic                       rst,
  input  dhc_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dhc_pkg::HUE_W-1:0]  hue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 blue,
  output logic [7:0]                 green,
  output logic [7:0]                 red
);

  localparam int NSTG   = 4;
  localparam int TERM_W = 17;
  localparam int NUM_W  = 26;
  localparam int FRAC_W = 6;
  localparam logic signed [TERM_W-1:0] ONE_Q  = 17'sd15360;
  localparam logic signed [NUM_W-1:0]  CH_DEN = 26'sd3932160;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4
  } sector_t;

  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  // floor(255 * num / (256*256*60)) with clamp; 255/15 = 17 and the rest is 2^18
  function automatic logic [7:0] to_byte(num_t num);
    logic [21:0] nu;
    logic [26:0] prod;
    nu   = num[21:0];
    prod = ({5'd0, nu} << 4) + {5'd0, nu};
    if (num <= 0) begin
      to_byte = 8'd0;
    end else if (num >= CH_DEN) begin
      to_byte = 8'd255;
    end else begin
      to_byte = prod[25:18];
    end
  endfunction

  logic [NSTG-1:0]     vld;
  logic [NSTG-1:0]     adv;

  sector_t             sec_next, sec;
  logic [FRAC_W-1:0]   frac_next, frac;
  term_t               fr_next, fg_next, fb_next;
  term_t               fr, fg, fb;
  num_t                nr, ng, nb;

  logic [14:0]         rs, ts;
  logic [FRAC_W-1:0]   rinv;
  logic signed [9:0]   sd;
  logic signed [10:0]  vs;
  term_t               tq, tt, tp;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    if (hue >= 8'd240) begin
      sec_next  = SEC_BM;
      frac_next = FRAC_W'(hue - 8'd240);
    end else if (hue >= 8'd180) begin
      sec_next  = SEC_CB;
      frac_next = FRAC_W'(hue - 8'd180);
    end else if (hue >= 8'd120) begin
      sec_next  = SEC_GC;
      frac_next = FRAC_W'(hue - 8'd120);
    end else if (hue >= 8'd60) begin
      sec_next  = SEC_YG;
      frac_next = FRAC_W'(hue - 8'd60);
    end else begin
      sec_next  = SEC_RY;
      frac_next = FRAC_W'(hue);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec  <= sec_next;
      frac <= frac_next;
    end
  end

  always_comb begin
    rinv = FRAC_W'(6'd60 - frac);
    rs   = 15'(frac) * 15'(cfg.saturation);
    ts   = 15'(rinv) * 15'(cfg.saturation);
    sd   = 10'sd256 - signed'({1'b0, cfg.saturation});
    tq   = ONE_Q - signed'({2'b00, rs});
    tt   = ONE_Q - signed'({2'b00, ts});
    tp   = TERM_W'(sd) * 17'sd60;
    case (sec)
      SEC_RY: begin fr_next = ONE_Q; fg_next = tt;    fb_next = tp;    end
      SEC_YG: begin fr_next = tq;    fg_next = ONE_Q; fb_next = tp;    end
      SEC_GC: begin fr_next = tp;    fg_next = ONE_Q; fb_next = tt;    end
      SEC_CB: begin fr_next = tp;    fg_next = tq;    fb_next = ONE_Q; end
      SEC_BM: begin fr_next = tt;    fg_next = tp;    fb_next = ONE_Q; end
      default: begin fr_next = ONE_Q; fg_next = tp;   fb_next = tq;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      fr <= fr_next;
      fg <= fg_next;
      fb <= fb_next;
    end
  end

  assign vs = signed'({2'b00, cfg.value_level});

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      nr <= NUM_W'(fr) * NUM_W'(vs);
      ng <= NUM_W'(fg) * NUM_W'(vs);
      nb <= NUM_W'(fb) * NUM_W'(vs);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      red   <= to_byte(nr);
      green <= to_byte(ng);
      blue  <= to_byte(nb);
    end
  end

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> frac < 6'd60)
    else $error("hue fraction out of range");

endmodule

// ----- hw/rtl/disparity_hue_colorizer.sv -----
// Disparity to BGR colorizer, nine-stage pipeline.
// Each pixel is registered through the hue-divider stages and then the shade stages.
// Throughput: one pixel per cycle; stalls are absorbed stage by stage.
// Hue division takes four stages, two quotient bits per stage.
// Reset: pipeline valids clear; max_disparity 255, saturation and value 256.
module disparity_hue_colorizer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dhc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dhc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  dhc_pix_if.sink                      pix,
  dhc_rgb_if.source                    rgb
);

  dhc_pkg::cfg_t              cfg;
  logic                       hue_valid;
  logic                       hue_ready;
  logic [dhc_pkg::HUE_W-1:0]  hue;

  dhc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhc_hue_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .disparity (pix.disparity),
    .hue_valid (hue_valid),
    .hue_ready (hue_ready),
    .hue       (hue)
  );

  dhc_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (hue_valid),
    .in_ready  (hue_ready),
    .hue       (hue),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .blue      (rgb.blue),
    .green     (rgb.green),
    .red       (rgb.red)
  );

endmodule
